// ===== hw/rtl/hilb_pkg.sv =====
package hilb_pkg;

   localparam int MAX_CURVE_LEVEL = 8;

   localparam int INDEX_W   = 16;
   localparam int COORD_W   = 10;
   localparam int LEVEL_W   = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 4;

   localparam int IDX_EXT_W = (2 * MAX_CURVE_LEVEL > INDEX_W) ? 2 * MAX_CURVE_LEVEL : INDEX_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURVE_LEVEL = 4'd0,
      CSR_CURVE_TYPE  = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      CURVE_A = 2'd0,
      CURVE_B = 2'd1,
      CURVE_C = 2'd2,
      CURVE_D = 2'd3
   } curve_type_type;

   typedef enum logic [1:0] {
      QUAD_ENTER  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_EXIT   = 2'd3
   } quadrant_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               index_out_of_range;
   } hilb_result_type;

endpackage

// ===== hw/rtl/hilb_if.sv =====
interface hilb_req_if;
   logic                         valid;
   logic                         ready;
   logic [hilb_pkg::INDEX_W-1:0] point_index;

   modport source (output valid, output point_index, input ready);
   modport sink   (input valid, input point_index, output ready);
endinterface

interface hilb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hilb_pkg::COORD_W-1:0] point_x;
   logic [hilb_pkg::COORD_W-1:0] point_y;
   logic                         index_out_of_range;

   modport source (output valid, output point_x, output point_y, output index_out_of_range,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input index_out_of_range,
                   output ready);
endinterface

interface hilb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hilb_pkg::CSR_IDX_W-1:0] reg_index;
   logic [hilb_pkg::CSR_DAT_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hw/rtl/hilb_map.sv =====
module hilb_map (
   input  logic [hilb_pkg::INDEX_W-1:0] point_index,
   input  logic [hilb_pkg::LEVEL_W-1:0] level,
   input  hilb_pkg::curve_type_type     curve_type,
   output hilb_pkg::hilb_result_type    result
);

   always_comb begin
      logic [hilb_pkg::IDX_EXT_W-1:0] idx_ext;
      logic [hilb_pkg::COORD_W-1:0]   px;
      logic [hilb_pkg::COORD_W-1:0]   py;
      logic [hilb_pkg::COORD_W-1:0]   org;
      logic [hilb_pkg::COORD_W-1:0]   h;
      logic [hilb_pkg::COORD_W-1:0]   bm;
      logic [hilb_pkg::COORD_W-1:0]   a_val;
      logic [hilb_pkg::COORD_W-1:0]   b_val;
      hilb_pkg::quadrant_type         q;
      logic                           sw;
      logic                           sa;
      logic                           sb;
      logic                           t;
      logic                           oor;

      idx_ext = hilb_pkg::IDX_EXT_W'(point_index);

      oor = 1'b0;
      for (int p = 0; p < hilb_pkg::INDEX_W; p++) begin
         if (point_index[p] && (p >= 2 * int'(level))) oor = 1'b1;
      end

      org = hilb_pkg::COORD_W'(1) << level;
      px  = '0;
      py  = '0;
      unique case (curve_type)
         hilb_pkg::CURVE_A: begin
            px = org;
            py = org;
         end
         hilb_pkg::CURVE_B: begin
            px = org;
         end
         hilb_pkg::CURVE_C, hilb_pkg::CURVE_D: begin
         end
      endcase

      // frame: sw=0 puts a on x and b on y; sa, sb mark negative vectors
      sw    = 1'b0;
      sa    = 1'b0;
      sb    = 1'b0;
      t     = 1'b0;
      q     = hilb_pkg::QUAD_ENTER;
      h     = '0;
      bm    = '0;
      a_val = '0;
      b_val = '0;
      for (int k = hilb_pkg::MAX_CURVE_LEVEL; k >= 1; k--) begin
         if (k <= int'(level)) begin
            q     = hilb_pkg::quadrant_type'(idx_ext[2*k-1 -: 2]);
            h     = hilb_pkg::COORD_W'(1) << k;
            bm    = (q == hilb_pkg::QUAD_EXIT) ? (h << 1) : h;
            a_val = sa ? (hilb_pkg::COORD_W'(0) - h) : h;
            b_val = sb ? (hilb_pkg::COORD_W'(0) - bm) : bm;
            if (q != hilb_pkg::QUAD_ENTER) begin
               if (sw) py = py + a_val;
               else    px = px + a_val;
            end
            if (q == hilb_pkg::QUAD_THIRD || q == hilb_pkg::QUAD_EXIT) begin
               if (sw) px = px + b_val;
               else    py = py + b_val;
            end
            unique case (q)
               hilb_pkg::QUAD_ENTER: begin
                  sw = ~sw;
                  t  = sa;
                  sa = sb;
                  sb = t;
               end
               hilb_pkg::QUAD_EXIT: begin
                  sw = ~sw;
                  t  = sa;
                  sa = ~sb;
                  sb = ~t;
               end
               hilb_pkg::QUAD_SECOND, hilb_pkg::QUAD_THIRD: begin
               end
            endcase
         end
      end

      // take the cell center
      a_val = sa ? '1 : hilb_pkg::COORD_W'(1);
      b_val = sb ? '1 : hilb_pkg::COORD_W'(1);
      if (sw) begin
         py = py + a_val;
         px = px + b_val;
      end else begin
         px = px + a_val;
         py = py + b_val;
      end

      result.point_x            = oor ? '0 : px;
      result.point_y            = oor ? '0 : py;
      result.index_out_of_range = oor;
   end

endmodule

// ===== hw/rtl/hilbert_index_to_point.sv =====
// Hilbert curve index to grid point.
// req_port carries one point_index per transaction; rsp_port returns one
// transaction per index with point_x, point_y and index_out_of_range.
// csr_port writes curve_level (index 0) and curve_type (index 1); it is
// always ready and must be used only while no transaction is in flight.
// A curve_level of 0 acts as 1; any value above the maximum acts as the maximum.
// Indices at or above 4^level return zero coordinates with the flag set.
// An accepted transaction passes one input register, the combinational level
// walk and one result register before it appears on rsp_port. Throughput:
// one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input
// register still takes one more transaction; req_port.ready drops only
// when both are full.
// Reset clears both pipeline stages and sets curve_level 1, curve_type A.
module hilbert_index_to_point (
   input logic       clock,
   input logic       reset,
   hilb_req_if.sink  req_port,
   hilb_rsp_if.source rsp_port,
   hilb_csr_if.sink  csr_port
);

   logic [hilb_pkg::LEVEL_W-1:0] level_ff, level_in;
   hilb_pkg::curve_type_type     type_ff, type_in;
   logic [hilb_pkg::LEVEL_W-1:0] eff_level;

   logic                         s1_valid_ff, s1_valid_in;
   logic [hilb_pkg::INDEX_W-1:0] s1_index_ff, s1_index_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hilb_pkg::hilb_result_type    result_ff, result_in;

   logic req_ready;
   logic req_take;
   logic s2_load;
   logic csr_take;

   assign csr_port.ready = 1'b1;
   assign csr_take       = csr_port.valid;

   always_comb begin
      level_in = level_ff;
      type_in  = type_ff;
      if (csr_take) begin
         if (csr_port.reg_index == hilb_pkg::CSR_CURVE_LEVEL) level_in = csr_port.wr_data;
         if (csr_port.reg_index == hilb_pkg::CSR_CURVE_TYPE)
            type_in = hilb_pkg::curve_type_type'(csr_port.wr_data[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= hilb_pkg::LEVEL_W'(1);
         type_ff  <= hilb_pkg::CURVE_A;
      end else begin
         level_ff <= level_in;
         type_ff  <= type_in;
      end
   end

   always_comb begin
      priority if (level_ff == '0)
         eff_level = hilb_pkg::LEVEL_W'(1);
      else if (level_ff > hilb_pkg::LEVEL_W'(hilb_pkg::MAX_CURVE_LEVEL))
         eff_level = hilb_pkg::LEVEL_W'(hilb_pkg::MAX_CURVE_LEVEL);
      else
         eff_level = level_ff;
   end

   assign s2_load        = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_ready      = !s1_valid_ff || s2_load;
   assign req_take       = req_port.valid && req_ready;
   assign req_port.ready = req_ready;

   assign s1_valid_in  = req_ready ? req_port.valid : s1_valid_ff;
   assign s1_index_in  = req_take ? req_port.point_index : s1_index_ff;
   assign rsp_valid_in = (!rsp_valid_ff || rsp_port.ready) ? s1_valid_ff : rsp_valid_ff;

   hilb_pkg::hilb_result_type map_result;

   hilb_map u_map (
      .point_index (s1_index_ff),
      .level       (eff_level),
      .curve_type  (type_ff),
      .result      (map_result)
   );

   assign result_in = s2_load ? map_result : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= s1_index_in;
      result_ff   <= result_in;
   end

   assign rsp_port.valid              = rsp_valid_ff;
   assign rsp_port.point_x            = result_ff.point_x;
   assign rsp_port.point_y            = result_ff.point_y;
   assign rsp_port.index_out_of_range = result_ff.index_out_of_range;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.index_out_of_range |-> result_ff.point_x == '0 &&
      result_ff.point_y == '0)
      else $error("out-of-range result carries nonzero coordinates");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff && $stable(s1_index_ff))
      else $error("stalled input stage lost its transaction");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted transaction not held in input stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      eff_level != '0 && eff_level <= hilb_pkg::LEVEL_W'(hilb_pkg::MAX_CURVE_LEVEL))
      else $error("effective level outside supported range");

endmodule
